FILE: src/itoa_pkg.sv
// Shared types, codes and the digit-to-character table for the integer to ASCII formatter.
// Used by itoa_bcd and integer_to_ascii_formatter_core; depends on nothing else.
`default_nettype none
package itoa_pkg;

	// Mode codes carried in the cmd field.
	localparam logic [1:0] CmdSdec  = 2'd0;
	localparam logic [1:0] CmdUdec  = 2'd1;
	localparam logic [1:0] CmdHexLo = 2'd2;
	localparam logic [1:0] CmdHexUp = 2'd3;

	// Widths of the value, the decimal source word and its BCD image.
	localparam int ValW     = 64;
	localparam int BinW     = 32;
	localparam int DecDigs  = 10;
	localparam int BcdW     = 4 * DecDigs;
	localparam int HexDigs  = ValW / 4;
	localparam int StepW    = $clog2(BinW);
	localparam int NdigW    = $clog2(HexDigs + 1);

	localparam logic [7:0] CharMinus = 8'h2d;

	typedef struct packed {
		logic [1:0]      cmd;
		logic [ValW-1:0] value;
	} itoa_in_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       last;
		logic       negative;
	} itoa_out_t;

	// Maps one digit to its ASCII code, in lower or upper case for the letters.
	function automatic logic [7:0] digit_char(input logic [3:0] dig, input logic upper);
		logic [7:0] c;
		begin
			if (dig < 4'd10) begin
				c = 8'h30 + {4'd0, dig};
			end else if (upper) begin
				c = 8'h41 + {4'd0, dig - 4'd10};
			end else begin
				c = 8'h61 + {4'd0, dig - 4'd10};
			end
			return c;
		end
	endfunction

endpackage
`default_nettype wire

FILE: src/integer_to_ascii_formatter_core.sv
// Integer to ASCII formatter: one item in, 1 to 17 characters out, most significant first.
// Decimal items pass through the BCD unit (one bit per cycle), then leading zeros are dropped
// one at a time, then the characters are handed out one at a time. Hex items skip the conversion.
// A minus sign adds one character, and receiver stalls hold the emission; in_ready is high only
// while idle, so a new item is taken only after the last character of the previous one.
// Asynchronous active-low reset returns the sequencer to idle with no result pending.
`default_nettype none
module integer_to_ascii_formatter_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire itoa_pkg::itoa_in_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output itoa_pkg::itoa_out_t      out_item
);

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StConv = 2'd1;
	localparam logic [1:0] StTrim = 2'd2;
	localparam logic [1:0] StEmit = 2'd3;

	logic [1:0]                     state_q;
	logic [itoa_pkg::ValW-1:0]      digits_q;
	logic [itoa_pkg::NdigW-1:0]     ndig_q;
	logic                           neg_q;
	logic                           upper_q;
	logic                           sign_pend_q;
	logic                           out_valid_q;
	itoa_pkg::itoa_out_t            out_q;

	logic                           in_acc;
	logic                           is_hex;
	logic                           in_neg;
	logic [itoa_pkg::BinW-1:0]      lo_word;
	logic [itoa_pkg::BinW-1:0]      dec_mag;
	logic [itoa_pkg::ValW-1:0]      hex_mag;
	logic                           bcd_done;
	logic [itoa_pkg::BcdW-1:0]      bcd;
	logic                           out_free;
	logic                           emit;
	logic                           top_zero;

	assign in_ready = (state_q == StIdle);
	assign in_acc   = in_valid && in_ready;

	// Sign and magnitude of the incoming value for its mode.
	always_comb begin
		is_hex  = (in_item.cmd == itoa_pkg::CmdHexLo) || (in_item.cmd == itoa_pkg::CmdHexUp);
		lo_word = in_item.value[itoa_pkg::BinW-1:0];
		if (is_hex) begin
			in_neg = in_item.value[itoa_pkg::ValW-1];
		end else begin
			in_neg = (in_item.cmd == itoa_pkg::CmdSdec) && lo_word[itoa_pkg::BinW-1];
		end
		dec_mag = in_neg ? (~lo_word + 1'b1) : lo_word;
		hex_mag = in_neg ? (~in_item.value + 1'b1) : in_item.value;
	end

	itoa_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc && !is_hex),
		.bin    (dec_mag),
		.done   (bcd_done),
		.bcd    (bcd)
	);

	assign out_free = !out_valid_q || out_ready;
	assign emit     = (state_q == StEmit) && out_free;
	assign top_zero = (digits_q[itoa_pkg::ValW-1 -: 4] == 4'd0);

	// Sequencer: convert, drop leading zeros, then hand out one character per slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			ndig_q      <= '0;
			sign_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				StIdle: begin
					if (in_acc) begin
						if (is_hex) begin
							ndig_q  <= itoa_pkg::NdigW'(itoa_pkg::HexDigs);
							state_q <= StTrim;
						end else begin
							state_q <= StConv;
						end
					end
				end
				StConv: begin
					if (bcd_done) begin
						ndig_q  <= itoa_pkg::NdigW'(itoa_pkg::DecDigs);
						state_q <= StTrim;
					end
				end
				StTrim: begin
					if (top_zero && (ndig_q > itoa_pkg::NdigW'(1))) begin
						ndig_q <= ndig_q - 1'b1;
					end else begin
						sign_pend_q <= neg_q;
						state_q     <= StEmit;
					end
				end
				StEmit: begin
					if (emit) begin
						if (sign_pend_q) begin
							sign_pend_q <= 1'b0;
						end else begin
							ndig_q <= ndig_q - 1'b1;
							if (ndig_q == itoa_pkg::NdigW'(1)) begin
								state_q <= StIdle;
							end
						end
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	// Digit register, flags of the item and the output register.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			neg_q   <= in_neg;
			upper_q <= (in_item.cmd == itoa_pkg::CmdHexUp);
			if (is_hex) begin
				digits_q <= hex_mag;
			end
		end
		if ((state_q == StConv) && bcd_done) begin
			digits_q <= {bcd, {(itoa_pkg::ValW - itoa_pkg::BcdW){1'b0}}};
		end
		if ((state_q == StTrim) && top_zero && (ndig_q > itoa_pkg::NdigW'(1))) begin
			digits_q <= {digits_q[itoa_pkg::ValW-5:0], 4'd0};
		end
		if (emit) begin
			if (sign_pend_q) begin
				out_q.char_out <= itoa_pkg::CharMinus;
				out_q.last     <= 1'b0;
				out_q.negative <= 1'b1;
			end else begin
				out_q.char_out <= itoa_pkg::digit_char(digits_q[itoa_pkg::ValW-1 -: 4], upper_q);
				out_q.last     <= (ndig_q == itoa_pkg::NdigW'(1));
				out_q.negative <= neg_q;
				digits_q       <= {digits_q[itoa_pkg::ValW-5:0], 4'd0};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// The BCD unit finishes only while the sequencer waits for it.
	a_bcd_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_done |-> (state_q == StConv))
		else $error("BCD conversion finished outside the conversion state");

	// Trimming and emitting always keep at least one digit to print.
	a_digits_left: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == StTrim) || (state_q == StEmit)) |-> (ndig_q != '0))
		else $error("digit count reached zero before the last character");

	// The final character of a number is never the minus sign.
	a_last_not_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last) |-> (out_q.char_out != itoa_pkg::CharMinus))
		else $error("last character is a minus sign");

	// An accepted item closes the input until it has been formatted.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input ready right after an accepted item");

endmodule
`default_nettype wire

FILE: src/itoa_bcd.sv
// Iterative binary to BCD converter (shift and add three), one bit per cycle.
// Depends on itoa_pkg for widths.
`default_nettype none
module itoa_bcd (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [itoa_pkg::BinW-1:0]   bin,
	output logic                             done,
	output logic [itoa_pkg::BcdW-1:0]        bcd
);

	logic [itoa_pkg::BcdW-1:0]  bcd_q;
	logic [itoa_pkg::BinW-1:0]  bin_q;
	logic [itoa_pkg::BcdW-1:0]  adj;
	logic [itoa_pkg::StepW-1:0] step_q;
	logic                       active_q;
	logic                       done_q;
	logic                       final_step;

	// Add three to every BCD digit that is five or more before the shift.
	always_comb begin
		for (int i = 0; i < itoa_pkg::DecDigs; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign final_step = (step_q == itoa_pkg::StepW'(itoa_pkg::BinW - 1));

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= active_q && final_step;
			if (start) begin
				active_q <= 1'b1;
				step_q   <= '0;
			end else if (active_q) begin
				step_q <= step_q + 1'b1;
				if (final_step) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	// Shift register: source bits move into the BCD digits one at a time.
	always_ff @(posedge clk) begin
		if (start) begin
			bcd_q <= '0;
			bin_q <= bin;
		end else if (active_q) begin
			bcd_q <= {adj[itoa_pkg::BcdW-2:0], bin_q[itoa_pkg::BinW-1]};
			bin_q <= {bin_q[itoa_pkg::BinW-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule
`default_nettype wire

FILE: sim/integer_to_ascii_formatter_core_test.sv
// Testbench for integer_to_ascii_formatter_core: a directed table, then random items.
// Each character that comes out is checked against the table text or a local predictor
// of the decimal and hex text. Depends on itoa_pkg and the core.
module integer_to_ascii_formatter_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandomItems = 450;
	localparam int PhaseLen    = 40;
	localparam int LongHold    = 300;
	localparam int HoldAfter   = 60;
	localparam int PauseAt     = 200;
	localparam int DrainLimit  = 10000;
	localparam int TailCycles  = 100;
	localparam int MaxReports  = 10;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	itoa_pkg::itoa_in_t  in_item = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	itoa_pkg::itoa_out_t out_item;

	// Characters still owed by the core, oldest first.
	itoa_pkg::itoa_out_t pending_chars[$];
	// Directed table: an empty text means the row is checked by the predictor.
	itoa_pkg::itoa_in_t  table_items[$];
	string               table_text[$];

	int fault_count = 0;
	int items_taken = 0;
	int idle_phase = 0;
	logic hold_on = 1'b0;

	integer_to_ascii_formatter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #1 clk = ~clk;

	// Work out the text of one item and queue its characters.
	function automatic void predict_text(input itoa_pkg::itoa_in_t it);
		logic [63:0]         mag;
		logic [63:0]         base;
		logic [3:0]          dig;
		logic [7:0]          digits_rev[$];
		logic                neg;
		logic                upper;
		itoa_pkg::itoa_out_t c;
		neg = 1'b0;
		upper = (it.cmd == itoa_pkg::CmdHexUp);
		case (it.cmd)
			itoa_pkg::CmdSdec: begin
				base = 64'd10;
				if (it.value[31]) begin
					neg = 1'b1;
					mag = {32'd0, 32'd0 - it.value[31:0]};
				end else begin
					mag = {32'd0, it.value[31:0]};
				end
			end
			itoa_pkg::CmdUdec: begin
				base = 64'd10;
				mag = {32'd0, it.value[31:0]};
			end
			default: begin
				base = 64'd16;
				// The most negative value negates to itself and reads as its unsigned magnitude.
				if (it.value[63]) begin
					neg = 1'b1;
					mag = 64'd0 - it.value;
				end else begin
					mag = it.value;
				end
			end
		endcase
		// Digits come out least significant first.
		do begin
			dig = 4'(mag % base);
			if (dig < 4'd10) begin
				digits_rev.push_back(8'h30 + 8'(dig));
			end else if (upper) begin
				digits_rev.push_back(8'h41 + 8'(dig - 4'd10));
			end else begin
				digits_rev.push_back(8'h61 + 8'(dig - 4'd10));
			end
			mag = mag / base;
		end while (mag != 64'd0);
		if (neg) begin
			c.char_out = itoa_pkg::CharMinus;
			c.last = 1'b0;
			c.negative = 1'b1;
			pending_chars.push_back(c);
		end
		for (int i = digits_rev.size() - 1; i >= 0; i--) begin
			c.char_out = digits_rev[i];
			c.last = (i == 0);
			c.negative = neg;
			pending_chars.push_back(c);
		end
	endfunction

	task automatic add_row(input logic [1:0] cmd, input logic [63:0] value, input string text);
		itoa_pkg::itoa_in_t it;
		it.cmd = cmd;
		it.value = value;
		table_items.push_back(it);
		table_text.push_back(text);
	endtask

	// Offer one item, with a random gap first when the phase calls for one.
	task automatic offer_item(input itoa_pkg::itoa_in_t it);
		int pct;
		pct = (idle_phase == 1) ? 46 : (idle_phase == 3) ? 8 : 0;
		if (pct > 0 && $urandom_range(0, 99) < pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < pct);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// Record what each accepted item should produce.
	always @(posedge clk) begin : take_item
		int k;
		itoa_pkg::itoa_out_t c;
		if (arst_n && in_valid && in_ready) begin
			items_taken++;
			if (table_text.size() > 0 && items_taken <= table_items.size() &&
					table_text[items_taken - 1].len() > 0) begin
				for (k = 0; k < table_text[items_taken - 1].len(); k++) begin
					c.char_out = table_text[items_taken - 1].getc(k);
					c.last = (k == table_text[items_taken - 1].len() - 1);
					c.negative = (table_text[items_taken - 1].getc(0) == itoa_pkg::CharMinus);
					pending_chars.push_back(c);
				end
			end else begin
				predict_text(in_item);
			end
		end
	end

	// Compare each accepted character with the oldest one owed.
	always @(posedge clk) begin : check_char
		itoa_pkg::itoa_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				fault_count++;
				if (fault_count <= MaxReports) begin
					$display("unexpected character %h last %b negative %b",
						out_item.char_out, out_item.last, out_item.negative);
				end
			end else begin
				want = pending_chars.pop_front();
				if (out_item !== want) begin
					fault_count++;
					if (fault_count <= MaxReports) begin
						$display("mismatch: expected char %h last %b negative %b, got %h %b %b",
							want.char_out, want.last, want.negative,
							out_item.char_out, out_item.last, out_item.negative);
					end
				end
			end
		end
	end

	// Receiver: stalls at random by phase, and holds off once for a long stretch.
	initial begin : receiver
		int pct;
		forever begin
			@(posedge clk);
			pct = (idle_phase == 2) ? 46 : (idle_phase == 3) ? 8 : 0;
			out_ready <= !hold_on && ($urandom_range(0, 99) >= pct);
		end
	end

	// Long hold-off of the receiver while the sender keeps offering items.
	initial begin : long_hold
		wait (items_taken >= HoldAfter);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (LongHold) @(posedge clk);
		hold_on <= 1'b0;
	end

	initial begin : watchdog
		#1_000_000;
		$display("** integer_to_ascii_formatter_core: FAILED **");
		$finish;
	end

	initial begin : stimulus
		itoa_pkg::itoa_in_t it;
		logic [63:0]        v;
		logic [63:0]        p;
		int                 drained;

		// Zero in every mode.
		add_row(itoa_pkg::CmdSdec,  64'd0, "0");
		add_row(itoa_pkg::CmdUdec,  64'd0, "0");
		add_row(itoa_pkg::CmdHexLo, 64'd0, "0");
		add_row(itoa_pkg::CmdHexUp, 64'd0, "0");
		// Extremes of the 32-bit word in the decimal modes.
		add_row(itoa_pkg::CmdSdec,  64'h0000_0000_8000_0000, "-2147483648");
		add_row(itoa_pkg::CmdSdec,  64'h0000_0000_7fff_ffff, "2147483647");
		add_row(itoa_pkg::CmdSdec,  64'h0000_0000_ffff_ffff, "-1");
		add_row(itoa_pkg::CmdUdec,  64'h0000_0000_ffff_ffff, "4294967295");
		add_row(itoa_pkg::CmdUdec,  64'h0000_0000_8000_0000, "2147483648");
		// The high half is ignored by the decimal modes.
		add_row(itoa_pkg::CmdSdec,  64'hffff_ffff_0000_0005, "5");
		add_row(itoa_pkg::CmdUdec,  64'hdead_beef_0000_0000, "0");
		add_row(itoa_pkg::CmdSdec,  64'd9, "9");
		add_row(itoa_pkg::CmdSdec,  64'd10, "10");
		// Extremes of the 64-bit value in the hex modes.
		add_row(itoa_pkg::CmdHexLo, 64'h8000_0000_0000_0000, "-8000000000000000");
		add_row(itoa_pkg::CmdHexUp, 64'h8000_0000_0000_0000, "-8000000000000000");
		add_row(itoa_pkg::CmdHexLo, 64'h7fff_ffff_ffff_ffff, "7fffffffffffffff");
		add_row(itoa_pkg::CmdHexUp, 64'h7fff_ffff_ffff_ffff, "7FFFFFFFFFFFFFFF");
		add_row(itoa_pkg::CmdHexLo, 64'hffff_ffff_ffff_ffff, "-1");
		add_row(itoa_pkg::CmdHexLo, 64'h0000_0000_abcd_ef12, "abcdef12");
		add_row(itoa_pkg::CmdHexUp, 64'h0000_0000_abcd_ef12, "ABCDEF12");
		add_row(itoa_pkg::CmdHexLo, 64'hf, "f");
		add_row(itoa_pkg::CmdHexUp, 64'h10, "10");
		// Rows left to the predictor.
		add_row(itoa_pkg::CmdSdec,  64'h1234_5678_9abc_def0, "");
		add_row(itoa_pkg::CmdHexUp, 64'hfedc_ba98_7654_3210, "");
		add_row(itoa_pkg::CmdUdec,  64'd1_000_000_000, "");

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_items[i]) begin
			offer_item(table_items[i]);
		end

		for (int n = 0; n < RandomItems; n++) begin
			idle_phase <= (n / PhaseLen) % 4;
			// Once, let every owed character arrive before going on.
			if (n == PauseAt) begin
				in_valid <= 1'b0;
				// First let the item just accepted be recorded.
				@(posedge clk);
				while (pending_chars.size() != 0) @(posedge clk);
			end
			case ($urandom_range(0, 6))
				0: v = {$urandom, $urandom};
				1: v = 64'($urandom_range(0, 20));
				2: v = 64'd0 - 64'($urandom_range(1, 20));
				3: v = 64'd1 << $urandom_range(0, 63);
				4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
				5: v = {$urandom, 32'h8000_0000 - 32'($urandom_range(0, 1))};
				default: begin
					p = 64'd1;
					repeat ($urandom_range(0, 9)) p = p * 64'd10;
					v = {$urandom, 32'(p + 64'($urandom_range(0, 2)) - 64'd1)};
				end
			endcase
			if ($urandom_range(0, 3) == 0) begin
				v = ~v;
			end
			it.cmd = 2'($urandom_range(0, 3));
			it.value = v;
			offer_item(it);
		end
		in_valid <= 1'b0;
		idle_phase <= 0;

		// Drain what is still owed, then watch a while for stray characters.
		@(posedge clk);
		drained = 0;
		while (pending_chars.size() != 0 && drained < DrainLimit) begin
			@(posedge clk);
			drained++;
		end
		repeat (TailCycles) @(posedge clk);
		if (pending_chars.size() != 0) begin
			$display("%0d expected characters never arrived", pending_chars.size());
			fault_count += pending_chars.size();
		end

		if (fault_count == 0) begin
			$display("** integer_to_ascii_formatter_core: PASSED **");
		end else begin
			$display("** integer_to_ascii_formatter_core: FAILED **");
		end
		$finish;
	end

endmodule
